// ===== design/csea_pkg.sv =====
// ----------------------------------------------------------------------------
// csea_pkg: shared types and constants of the complex scalar elementwise ALU
// Operation and status codes, register indexes, the sideband record that
// travels down the pipeline, and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package csea_pkg;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DIVZERO = 2'd1;
    localparam logic [1:0] STAT_SAT     = 2'd2;

    localparam logic [1:0] REG_SCALAR_REAL = 2'd0;
    localparam logic [1:0] REG_SCALAR_IMAG = 2'd1;

    // quotient bits produced by the divider: floor of value times two
    localparam int QW = 33;

    typedef struct packed {
        logic [1:0]         func;
        logic               last;
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               sat;
        logic               dz;
        logic               ovf_r;
        logic               ovf_i;
        logic               neg_r;
        logic               neg_i;
    } t_side;

    // Returns {saturated, value} for a sign and magnitude.
    function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] mag);
        logic [32:0] res;
        if (neg) begin
            if (mag > 65'h0_8000_0000) res = {1'b1, 32'h8000_0000};
            else res = {1'b0, 32'(-mag[31:0])};
        end else begin
            if (mag > 65'h0_7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
            else res = {1'b0, mag[31:0]};
        end
        return res;
    endfunction

endpackage

// ===== design/csea_div.sv =====
// ----------------------------------------------------------------------------
// csea_div: pipelined restoring divider, two lanes sharing one divisor
// One quotient bit per stage for both the real and imaginary numerators.
// ----------------------------------------------------------------------------
module csea_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_ce,
    input  logic                    i_valid,
    input  csea_pkg::t_side         i_side,
    input  logic [63:0]             i_rem_r,
    input  logic [63:0]             i_rem_i,
    input  logic [csea_pkg::QW-1:0] i_low_r,
    input  logic [csea_pkg::QW-1:0] i_low_i,
    input  logic [63:0]             i_den,
    output logic                    o_valid,
    output csea_pkg::t_side         o_side,
    output logic [csea_pkg::QW-1:0] o_quo_r,
    output logic [csea_pkg::QW-1:0] o_quo_i
);

    localparam int NST = csea_pkg::QW;

    logic                    r_v    [0:NST];
    csea_pkg::t_side         r_side [0:NST];
    logic [63:0]             r_rem_r[0:NST];
    logic [63:0]             r_rem_i[0:NST];
    logic [csea_pkg::QW-1:0] r_low_r[0:NST];
    logic [csea_pkg::QW-1:0] r_low_i[0:NST];
    logic [csea_pkg::QW-1:0] r_q_r  [0:NST];
    logic [csea_pkg::QW-1:0] r_q_i  [0:NST];
    logic [63:0]             r_den  [0:NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_side[0]  <= i_side;
            r_rem_r[0] <= i_rem_r;
            r_rem_i[0] <= i_rem_i;
            r_low_r[0] <= i_low_r;
            r_low_i[0] <= i_low_i;
            r_q_r[0]   <= '0;
            r_q_i[0]   <= '0;
            r_den[0]   <= i_den;
        end
    end

    for (genvar j = 1; j <= NST; j++) begin : g_stage
        localparam int B = NST - j;
        logic [64:0] n_sh_r, n_sh_i, n_df_r, n_df_i;
        logic        n_ge_r, n_ge_i;

        assign n_sh_r = {r_rem_r[j-1], r_low_r[j-1][B]};
        assign n_sh_i = {r_rem_i[j-1], r_low_i[j-1][B]};
        assign n_df_r = n_sh_r - {1'b0, r_den[j-1]};
        assign n_df_i = n_sh_i - {1'b0, r_den[j-1]};
        assign n_ge_r = n_sh_r >= {1'b0, r_den[j-1]};
        assign n_ge_i = n_sh_i >= {1'b0, r_den[j-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_ce) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_side[j]  <= r_side[j-1];
                r_low_r[j] <= r_low_r[j-1];
                r_low_i[j] <= r_low_i[j-1];
                r_den[j]   <= r_den[j-1];
                r_rem_r[j] <= n_ge_r ? n_df_r[63:0] : n_sh_r[63:0];
                r_rem_i[j] <= n_ge_i ? n_df_i[63:0] : n_sh_i[63:0];
                r_q_r[j]   <= r_q_r[j-1] | (csea_pkg::QW'(n_ge_r) << B);
                r_q_i[j]   <= r_q_i[j-1] | (csea_pkg::QW'(n_ge_i) << B);
            end
        end
    end

    assign o_valid = r_v[NST];
    assign o_side  = r_side[NST];
    assign o_quo_r = r_q_r[NST];
    assign o_quo_i = r_q_i[NST];

endmodule

// ===== design/complex_scalar_elementwise_alu_top.sv =====
// ----------------------------------------------------------------------------
// complex_scalar_elementwise_alu_top: complex element op complex scalar
// Adds, subtracts, multiplies or divides each element by a configured scalar.
// ----------------------------------------------------------------------------
// One item enters every cycle while o_stall is low and passes through four
// front stages (input, products, sums, magnitudes), a divider stage per
// quotient bit (34 stages in all, carried by every operation so results stay
// in order) and an output register backed by a one-entry skid buffer. After
// a stall ends with the skid buffer full, the pipeline holds while it drains.
// Results are signed Q(32-FRAC_BITS).FRAC_BITS, saturated, with status.
module complex_scalar_elementwise_alu_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_elem_real,
    input  logic signed [31:0] i_elem_imag,
    input  logic               i_elem_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_res_real,
    output logic signed [31:0] o_res_imag,
    output logic [1:0]         o_res_status,
    output logic               o_res_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int OVW = 96;

    logic signed [31:0] r_scalar_re, r_scalar_im;
    logic               ce;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scalar_re <= 32'(64'd1 << FRAC_BITS);
            r_scalar_im <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                csea_pkg::REG_SCALAR_REAL: r_scalar_re <= i_cfg_data;
                csea_pkg::REG_SCALAR_IMAG: r_scalar_im <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: input
    logic               r_v0;
    logic [1:0]         r_func0;
    logic               r_last0;
    logic signed [31:0] r_er0, r_ei0;

    // stage 1: products and add/subtract
    logic               r_v1;
    csea_pkg::t_side    r_side1;
    logic signed [63:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri, r_d_rr, r_d_ii;

    // stage 2: sums
    logic               r_v2;
    csea_pkg::t_side    r_side2;
    logic signed [64:0] r_num_r, r_num_i;
    logic [63:0]        r_den2;

    // stage 3: magnitudes
    logic               r_v3;
    csea_pkg::t_side    r_side3;
    logic [63:0]        r_mag_r, r_mag_i, r_den3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (ce) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    logic signed [32:0] n_as_r, n_as_i;
    logic [32:0]        n_sat_r, n_sat_i;
    csea_pkg::t_side    n_side1, n_side3;

    always_comb begin
        if (r_func0 == csea_pkg::FUNC_SUB) begin
            n_as_r = 33'(r_er0) - 33'(r_scalar_re);
            n_as_i = 33'(r_ei0) - 33'(r_scalar_im);
        end else begin
            n_as_r = 33'(r_er0) + 33'(r_scalar_re);
            n_as_i = 33'(r_ei0) + 33'(r_scalar_im);
        end
        n_sat_r = csea_pkg::sat_mag(n_as_r[32], n_as_r[32] ? 65'(-n_as_r) : 65'(n_as_r));
        n_sat_i = csea_pkg::sat_mag(n_as_i[32], n_as_i[32] ? 65'(-n_as_i) : 65'(n_as_i));
        n_side1        = '0;
        n_side1.func   = r_func0;
        n_side1.last   = r_last0;
        n_side1.res_re = n_sat_r[31:0];
        n_side1.res_im = n_sat_i[31:0];
        n_side1.sat    = n_sat_r[32] | n_sat_i[32];
    end

    always_comb begin
        n_side3       = r_side2;
        n_side3.neg_r = r_num_r[64];
        n_side3.neg_i = r_num_i[64];
        n_side3.dz    = r_den2 == '0;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_func0 <= i_func;
            r_last0 <= i_elem_last;
            r_er0   <= i_elem_real;
            r_ei0   <= i_elem_imag;

            r_p_rr <= r_er0 * r_scalar_re;
            r_p_ii <= r_ei0 * r_scalar_im;
            r_p_ir <= r_ei0 * r_scalar_re;
            r_p_ri <= r_er0 * r_scalar_im;
            r_d_rr <= r_scalar_re * r_scalar_re;
            r_d_ii <= r_scalar_im * r_scalar_im;
            r_side1 <= n_side1;

            r_side2 <= r_side1;
            r_den2  <= 64'(r_d_rr) + 64'(r_d_ii);
            if (r_side1.func == csea_pkg::FUNC_DIV) begin
                r_num_r <= 65'(r_p_rr) + 65'(r_p_ii);
                r_num_i <= 65'(r_p_ir) - 65'(r_p_ri);
            end else begin
                r_num_r <= 65'(r_p_rr) - 65'(r_p_ii);
                r_num_i <= 65'(r_p_ir) + 65'(r_p_ri);
            end

            r_side3 <= n_side3;
            r_mag_r <= r_num_r[64] ? 64'(-r_num_r) : r_num_r[63:0];
            r_mag_i <= r_num_i[64] ? 64'(-r_num_i) : r_num_i[63:0];
            r_den3  <= r_den2;
        end
    end

    // rounding for multiply, overflow check and divider setup
    csea_pkg::t_side         n_side4;
    logic [64:0]             n_rnd_r, n_rnd_i;
    logic [32:0]             n_ms_r, n_ms_i;
    logic [OVW-1:0]          n_lim;
    logic [63:0]             n_rem_r, n_rem_i;
    logic [csea_pkg::QW-1:0] n_low_r, n_low_i;

    always_comb begin
        n_rnd_r = (65'(r_mag_r) + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        n_rnd_i = (65'(r_mag_i) + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        n_ms_r  = csea_pkg::sat_mag(r_side3.neg_r, n_rnd_r);
        n_ms_i  = csea_pkg::sat_mag(r_side3.neg_i, n_rnd_i);
        n_lim   = OVW'(r_den3) << (32 - FRAC_BITS);
        n_side4 = r_side3;
        n_side4.ovf_r = OVW'(r_mag_r) >= n_lim;
        n_side4.ovf_i = OVW'(r_mag_i) >= n_lim;
        if (r_side3.func == csea_pkg::FUNC_MUL) begin
            n_side4.res_re = n_ms_r[31:0];
            n_side4.res_im = n_ms_i[31:0];
            n_side4.sat    = n_ms_r[32] | n_ms_i[32];
        end
        n_rem_r = r_mag_r >> (32 - FRAC_BITS);
        n_rem_i = r_mag_i >> (32 - FRAC_BITS);
        n_low_r = csea_pkg::QW'(r_mag_r << (FRAC_BITS + 1));
        n_low_i = csea_pkg::QW'(r_mag_i << (FRAC_BITS + 1));
    end

    logic                    dv_valid;
    csea_pkg::t_side         dv_side;
    logic [csea_pkg::QW-1:0] dv_quo_r, dv_quo_i;

    csea_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_v3),
        .i_side  (n_side4),
        .i_rem_r (n_rem_r),
        .i_rem_i (n_rem_i),
        .i_low_r (n_low_r),
        .i_low_i (n_low_i),
        .i_den   (r_den3),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_quo_r (dv_quo_r),
        .o_quo_i (dv_quo_i)
    );

    // final rounding of the quotient and result select
    logic [32:0]        n_qr, n_qi, n_ds_r, n_ds_i;
    logic signed [31:0] n_out_re, n_out_im;
    logic [1:0]         n_out_st;
    logic               n_sat;

    always_comb begin
        n_qr   = 33'((34'(dv_quo_r) + 34'd1) >> 1);
        n_qi   = 33'((34'(dv_quo_i) + 34'd1) >> 1);
        n_ds_r = csea_pkg::sat_mag(dv_side.neg_r, 65'(n_qr));
        n_ds_i = csea_pkg::sat_mag(dv_side.neg_i, 65'(n_qi));
        if (dv_side.ovf_r) n_ds_r = {1'b1, dv_side.neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF};
        if (dv_side.ovf_i) n_ds_i = {1'b1, dv_side.neg_i ? 32'h8000_0000 : 32'h7FFF_FFFF};
        n_out_re = dv_side.res_re;
        n_out_im = dv_side.res_im;
        n_sat    = dv_side.sat;
        n_out_st = csea_pkg::STAT_OK;
        if (dv_side.func == csea_pkg::FUNC_DIV) begin
            if (dv_side.dz) begin
                n_out_re = '0;
                n_out_im = '0;
                n_sat    = 1'b0;
                n_out_st = csea_pkg::STAT_DIVZERO;
            end else begin
                n_out_re = n_ds_r[31:0];
                n_out_im = n_ds_i[31:0];
                n_sat    = n_ds_r[32] | n_ds_i[32];
            end
        end
        if (n_sat) n_out_st = csea_pkg::STAT_SAT;
    end

    // output register and skid buffer
    logic               r_ov, r_skid_v;
    logic signed [31:0] r_sk_re, r_sk_im;
    logic [1:0]         r_sk_st;
    logic               r_sk_last;
    logic signed [31:0] r_o_re, r_o_im;
    logic [1:0]         r_o_st;
    logic               r_o_last;

    assign ce      = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            if (r_skid_v) begin
                r_ov     <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_ov <= dv_valid;
            end
        end else if (dv_valid && ce) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            if (r_skid_v) begin
                r_o_re   <= r_sk_re;
                r_o_im   <= r_sk_im;
                r_o_st   <= r_sk_st;
                r_o_last <= r_sk_last;
            end else begin
                r_o_re   <= n_out_re;
                r_o_im   <= n_out_im;
                r_o_st   <= n_out_st;
                r_o_last <= dv_side.last;
            end
        end else if (ce) begin
            // park the arriving result while the output holds
            r_sk_re   <= n_out_re;
            r_sk_im   <= n_out_im;
            r_sk_st   <= n_out_st;
            r_sk_last <= dv_side.last;
        end
    end

    assign o_valid      = r_ov;
    assign o_res_real   = r_o_re;
    assign o_res_imag   = r_o_im;
    assign o_res_status = r_o_st;
    assign o_res_last   = r_o_last;

`ifndef SYNTHESIS
    a_skid_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(o_valid && i_stall))
        else $error("skid filled without an output stall");

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid holds data while output is empty");

    a_divzero_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res_status == csea_pkg::STAT_DIVZERO)
            |-> (o_res_real == '0 && o_res_imag == '0))
        else $error("divide by zero result not cleared");
`endif

endmodule
